@@ src/fnv1a_fmix_shard_hash_macros.svh @@
// Assertion macros for the shard hash block.
// Users supply clk and rst in scope; no other dependencies.
`ifndef FNV1A_FMIX_SHARD_HASH_MACROS_SVH
`define FNV1A_FMIX_SHARD_HASH_MACROS_SVH

// Same-cycle implication, disabled during reset
`define FSH_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("shard hash check failed");

// Next-cycle implication, disabled during reset
`define FSH_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("shard hash check failed");

`endif

@@ src/fsh_pkg.sv @@
// Package for the shard hash block: constants, types and helper functions.
// No dependencies.
package fsh_pkg;

  localparam int KEY_W   = 8;
  localparam int HASH_W  = 64;
  localparam int SHARD_W = 16;
  localparam int HALF_W  = 32;

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic REG_SHARDS = 1'b0;

  localparam logic [HASH_W-1:0] FNV_BASIS = 64'hcbf29ce484222325;
  localparam logic [HASH_W-1:0] FNV_MUL   = 64'h00000100000001b3;
  localparam logic [HASH_W-1:0] MIX_MUL_A = 64'hff51afd7ed558ccd;
  localparam logic [HASH_W-1:0] MIX_MUL_B = 64'hc4ceb9fe1a85ec53;
  localparam int                MIX_SHIFT = 33;

  localparam logic [SHARD_W-1:0] SHARDS_RESET = 16'd16;

  localparam logic [1:0] MUL_LAST_STEP = 2'd2;
  localparam int         MOD_CNT_W     = 6;
  localparam logic [MOD_CNT_W-1:0] MOD_LAST_CNT = 6'd63;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FNV,
    ST_MIX_A,
    ST_MIX_B,
    ST_MOD,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic              start;
    logic [HASH_W-1:0] a;
    logic [HASH_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [HASH_W-1:0] product;
  } mul_rsp_t;

  typedef struct packed {
    logic               start;
    logic [HASH_W-1:0]  dividend;
    logic [SHARD_W-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic               done;
    logic [SHARD_W-1:0] remainder;
  } mod_rsp_t;

  function automatic logic [HASH_W-1:0] xor_shift(input logic [HASH_W-1:0] v);
    return v ^ (v >> MIX_SHIFT);
  endfunction

endpackage

@@ src/fsh_if.sv @@
// Stream interfaces for the shard hash block: key bytes in, hash results out.
// Depends on fsh_pkg.
interface fsh_in_if;
  import fsh_pkg::*;
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] key_byte;
  logic             last_byte;

  modport source (output valid, key_byte, last_byte, input ready);
  modport sink   (input valid, key_byte, last_byte, output ready);
endinterface

interface fsh_out_if;
  import fsh_pkg::*;
  logic               valid;
  logic               ready;
  logic [HASH_W-1:0]  key_hash;
  logic [SHARD_W-1:0] shard_number;

  modport source (output valid, key_hash, shard_number, input ready);
  modport sink   (input valid, key_hash, shard_number, output ready);
endinterface

@@ src/fsh_mul64.sv @@
// Iterative 64x64 multiplier, low 64 bits of the product, one 32x32 partial
// product per cycle (low x low, low x high, then high x low). Depends on fsh_pkg.
module fsh_mul64 (
  input  logic              clk,
  input  logic              rst,
  input  fsh_pkg::mul_req_t req,
  output fsh_pkg::mul_rsp_t rsp
);
  import fsh_pkg::*;

  logic [HASH_W-1:0]   a;
  logic [HASH_W-1:0]   b;
  logic [HASH_W-1:0]   acc;
  logic [HASH_W-1:0]   acc_next;
  logic [1:0]          step;
  logic                busy;
  logic [HALF_W-1:0]   op_x;
  logic [HALF_W-1:0]   op_y;
  logic [2*HALF_W-1:0] prod;

  always_comb begin
    case (step)
      2'd0: begin
        op_x = a[HALF_W-1:0];
        op_y = b[HALF_W-1:0];
      end
      2'd1: begin
        op_x = a[HALF_W-1:0];
        op_y = b[HASH_W-1:HALF_W];
      end
      2'd2: begin
        op_x = a[HASH_W-1:HALF_W];
        op_y = b[HALF_W-1:0];
      end
      default: begin
        op_x = '0;
        op_y = '0;
      end
    endcase
  end

  assign prod = {{HALF_W{1'b0}}, op_x} * {{HALF_W{1'b0}}, op_y};

  always_comb begin
    if (step == 2'd0) begin
      acc_next = prod;
    end else begin
      acc_next = {acc[HASH_W-1:HALF_W] + prod[HALF_W-1:0], acc[HALF_W-1:0]};
    end
  end

  assign rsp.done    = busy && (step == MUL_LAST_STEP);
  assign rsp.product = acc_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= 2'd0;
    end else if (req.start) begin
      busy <= 1'b1;
      step <= 2'd0;
    end else if (busy) begin
      if (step == MUL_LAST_STEP) begin
        busy <= 1'b0;
      end
      step <= step + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a <= req.a;
      b <= req.b;
    end else if (busy) begin
      acc <= acc_next;
    end
  end

endmodule

@@ src/fsh_mod.sv @@
// Bit-serial restoring modulo of a 64-bit value by a 16-bit divisor,
// one dividend bit per cycle. Depends on fsh_pkg.
module fsh_mod (
  input  logic              clk,
  input  logic              rst,
  input  fsh_pkg::mod_req_t req,
  output fsh_pkg::mod_rsp_t rsp
);
  import fsh_pkg::*;

  logic [HASH_W-1:0]    dvd;
  logic [SHARD_W-1:0]   divisor;
  logic [SHARD_W-1:0]   rem;
  logic [SHARD_W-1:0]   rem_next;
  logic [SHARD_W:0]     trial;
  logic [SHARD_W:0]     diff;
  logic [MOD_CNT_W-1:0] cnt;
  logic                 busy;

  assign trial = {rem, dvd[HASH_W-1]};
  assign diff  = trial - {1'b0, divisor};

  always_comb begin
    if (trial >= {1'b0, divisor}) begin
      rem_next = diff[SHARD_W-1:0];
    end else begin
      rem_next = trial[SHARD_W-1:0];
    end
  end

  assign rsp.done      = busy && (cnt == MOD_LAST_CNT);
  assign rsp.remainder = (divisor == '0) ? '0 : rem_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      if (cnt == MOD_LAST_CNT) begin
        busy <= 1'b0;
      end
      cnt <= cnt + MOD_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd     <= req.dividend;
      divisor <= req.divisor;
      rem     <= '0;
    end else if (busy) begin
      dvd <= {dvd[HASH_W-2:0], 1'b0};
      rem <= rem_next;
    end
  end

endmodule

@@ src/fnv1a_fmix_shard_hash.sv @@
// Shard hash top level: FNV-1a 64 over a byte stream, 64-bit finalizer mix,
// and reduction modulo a configured shard count.
// Depends on fsh_pkg, fsh_if, fsh_mul64, fsh_mod and the macros header.
//
// Usage:
//   key_in carries one key byte per transaction, last_byte set on the final
//   byte of a key. hash_out carries one transaction per key: the mixed hash and
//   that hash modulo the shard modulus (0 when the modulus is 0). The user must
//   write the shard modulus at APB address 0 only while idle; not enforced.
//
// Timing:
//   Every multiply runs on one shared 32x32 multiplier. A byte that is not
//   last holds off the next acceptance for one FNV multiply. A last byte adds
//   two finalizer multiplies, a bit-serial modulo and an output load; hash_out
//   goes valid together with key_in ready. Results sit in an output register;
//   a stalled receiver holds the block only when a second key finishes before
//   the first result is taken. Reset empties the output register, returns the
//   running hash to the FNV offset basis and sets the shard modulus to 16.
module fnv1a_fmix_shard_hash (
  input  logic                        clk,
  input  logic                        rst,
  fsh_in_if.sink                      key_in,
  fsh_out_if.source                   hash_out,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fsh_pkg::ADDR_W-1:0]  paddr,
  input  logic [fsh_pkg::DATA_W-1:0]  pwdata,
  output logic [fsh_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import fsh_pkg::*;

  state_t             state;
  state_t             state_next;
  logic [HASH_W-1:0]  running_hash;
  logic [HASH_W-1:0]  mixed;
  logic [SHARD_W-1:0] shard;
  logic [SHARD_W-1:0] shard_mod;
  logic               last_flag;
  logic               accept;
  logic               out_free;
  logic               cfg_write;
  logic [HASH_W-1:0]  product_mix;
  mul_req_t           mul_req;
  mul_rsp_t           mul_rsp;
  mod_req_t           mod_req;
  mod_rsp_t           mod_rsp;

  fsh_mul64 u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  fsh_mod u_mod (
    .clk (clk),
    .rst (rst),
    .req (mod_req),
    .rsp (mod_rsp)
  );

  assign accept      = key_in.valid && key_in.ready;
  assign out_free    = !hash_out.valid || hash_out.ready;
  assign product_mix = xor_shift(mul_rsp.product);

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_SHARDS);
  assign prdata    = (paddr[2] == REG_SHARDS) ?
                     {{(DATA_W-SHARD_W){1'b0}}, shard_mod} : '0;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (accept) state_next = ST_FNV;
      ST_FNV: begin
        if (mul_rsp.done) state_next = last_flag ? ST_MIX_A : ST_IDLE;
      end
      ST_MIX_A: if (mul_rsp.done) state_next = ST_MIX_B;
      ST_MIX_B: if (mul_rsp.done) state_next = ST_MOD;
      ST_MOD:   if (mod_rsp.done) state_next = ST_EMIT;
      ST_EMIT:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    key_in.ready     = (state == ST_IDLE);
    mul_req.start    = 1'b0;
    mul_req.a        = product_mix;
    mul_req.b        = MIX_MUL_A;
    mod_req.start    = 1'b0;
    mod_req.dividend = product_mix;
    mod_req.divisor  = shard_mod;
    case (state)
      ST_IDLE: begin
        mul_req.start = accept;
        mul_req.a     = running_hash ^ {{(HASH_W-KEY_W){1'b0}}, key_in.key_byte};
        mul_req.b     = FNV_MUL;
      end
      ST_FNV: begin
        mul_req.start = mul_rsp.done && last_flag;
      end
      ST_MIX_A: begin
        mul_req.start = mul_rsp.done;
        mul_req.b     = MIX_MUL_B;
      end
      ST_MIX_B: begin
        mod_req.start = mul_rsp.done;
      end
      default: begin
        mul_req.start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      running_hash   <= FNV_BASIS;
      shard_mod      <= SHARDS_RESET;
      hash_out.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        shard_mod <= pwdata[SHARD_W-1:0];
      end
      if (state == ST_FNV && mul_rsp.done) begin
        running_hash <= last_flag ? FNV_BASIS : mul_rsp.product;
      end
      if (state == ST_EMIT && out_free) begin
        hash_out.valid <= 1'b1;
      end else if (hash_out.ready) begin
        hash_out.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      last_flag <= key_in.last_byte;
    end
    if (state == ST_MIX_B && mul_rsp.done) begin
      mixed <= product_mix;
    end
    if (state == ST_MOD && mod_rsp.done) begin
      shard <= mod_rsp.remainder;
    end
    if (state == ST_EMIT && out_free) begin
      hash_out.key_hash     <= mixed;
      hash_out.shard_number <= shard;
    end
  end

`include "fnv1a_fmix_shard_hash_macros.svh"

  `FSH_ASSERT_IMPL(a_mul_start_src, mul_req.start, accept || mul_rsp.done)
  `FSH_ASSERT_IMPL(a_mod_done_state, mod_rsp.done, state == ST_MOD)
  `FSH_ASSERT_NEXT(a_accept_to_fnv, accept, state == ST_FNV)
  `FSH_ASSERT_IMPL(a_out_rise, $rose(hash_out.valid), $past(state) == ST_EMIT)

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for fnv1a_fmix_shard_hash: byte-serial keys in, hash and shard out.
// Predicts results in-house (directed rows may pin the shard), compares field by field;
// APB writes set the shard count. Depends on fsh_pkg, fsh_if and the block's RTL.
module tb;
  import fsh_pkg::*;

  localparam logic [HASH_W-1:0] OFFSET_BASIS = 64'hcbf29ce484222325;
  localparam logic [HASH_W-1:0] FNV_MULT     = 64'h00000100000001b3;
  localparam logic [HASH_W-1:0] FMIX_MULT_1  = 64'hff51afd7ed558ccd;
  localparam logic [HASH_W-1:0] FMIX_MULT_2  = 64'hc4ceb9fe1a85ec53;
  localparam int                FMIX_SHR     = 33;

  localparam logic [ADDR_W-1:0] ADDR_SHARDS = ADDR_W'(4 * REG_SHARDS);
  localparam logic [ADDR_W-1:0] ADDR_NO_REG = ADDR_W'(4);

  localparam int SETTLE_CYCLES   = 12;
  localparam int TAIL_CYCLES     = 80;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int PHASES          = 8;
  localparam int BYTES_PER_PHASE = 210;

  typedef enum logic {ROW_KEY, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic [ADDR_W-1:0]  addr;
    logic [31:0]        value;
    logic               last;
    logic               pinned;
    logic [SHARD_W-1:0] shard;
  } step_row_t;

  typedef struct packed {
    logic [HASH_W-1:0]  key_hash;
    logic [SHARD_W-1:0] shard_number;
  } hash_result_t;

  typedef struct packed {
    logic               pinned;
    logic [SHARD_W-1:0] shard;
  } shard_pin_t;

  localparam int DIRECTED_ROWS = 24;
  localparam step_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{ROW_KEY,   ADDR_SHARDS, 32'h0000_0000, 1'b1, 1'b0, 16'd0},
    '{ROW_KEY,   ADDR_SHARDS, 32'h0000_00ff, 1'b1, 1'b0, 16'd0},
    '{ROW_KEY,   ADDR_SHARDS, 32'h0000_006b, 1'b0, 1'b0, 16'd0},
    '{ROW_KEY,   ADDR_SHARDS, 32'h0000_0065, 1'b0, 1'b0, 16'd0},
    '{ROW_KEY,   ADDR_SHARDS, 32'h0000_0079, 1'b1, 1'b0, 16'd0},
    '{ROW_WRITE, ADDR_SHARDS, 32'h0000_0000, 1'b0, 1'b0, 16'd0},
    '{ROW_KEY,   ADDR_SHARDS, 32'h0000_0000, 1'b1, 1'b1, 16'd0},
    '{ROW_KEY,   ADDR_SHARDS, 32'h0000_00ff, 1'b1, 1'b1, 16'd0},
    '{ROW_KEY,   ADDR_SHARDS, 32'h0000_0080, 1'b0, 1'b0, 16'd0},
    '{ROW_KEY,   ADDR_SHARDS, 32'h0000_0001, 1'b1, 1'b1, 16'd0},
    '{ROW_WRITE, ADDR_SHARDS, 32'h0000_0001, 1'b0, 1'b0, 16'd0},
    '{ROW_KEY,   ADDR_SHARDS, 32'h0000_007f, 1'b1, 1'b1, 16'd0},
    '{ROW_KEY,   ADDR_SHARDS, 32'h0000_0055, 1'b0, 1'b0, 16'd0},
    '{ROW_KEY,   ADDR_SHARDS, 32'h0000_00aa, 1'b1, 1'b1, 16'd0},
    '{ROW_WRITE, ADDR_SHARDS, 32'hffff_ffff, 1'b0, 1'b0, 16'd0},
    '{ROW_KEY,   ADDR_SHARDS, 32'h0000_00ff, 1'b0, 1'b0, 16'd0},
    '{ROW_KEY,   ADDR_SHARDS, 32'h0000_00ff, 1'b0, 1'b0, 16'd0},
    '{ROW_KEY,   ADDR_SHARDS, 32'h0000_0000, 1'b1, 1'b0, 16'd0},
    '{ROW_WRITE, ADDR_NO_REG, 32'h0000_0007, 1'b0, 1'b0, 16'd0},
    '{ROW_KEY,   ADDR_SHARDS, 32'h0000_0031, 1'b1, 1'b0, 16'd0},
    '{ROW_WRITE, ADDR_SHARDS, 32'ha5a5_8000, 1'b0, 1'b0, 16'd0},
    '{ROW_KEY,   ADDR_SHARDS, 32'h0000_0000, 1'b1, 1'b0, 16'd0},
    '{ROW_WRITE, ADDR_SHARDS, 32'h0000_0002, 1'b0, 1'b0, 16'd0},
    '{ROW_KEY,   ADDR_SHARDS, 32'h0000_0001, 1'b1, 1'b0, 16'd0}
  };

  logic               clk = 1'b0;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [ADDR_W-1:0]  paddr;
  logic [DATA_W-1:0]  pwdata;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  fsh_in_if  key_bus ();
  fsh_out_if hash_bus ();

  fnv1a_fmix_shard_hash u_dut (
    .clk      (clk),
    .rst      (rst),
    .key_in   (key_bus),
    .hash_out (hash_bus),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  hash_result_t       pending_hashes [$];
  shard_pin_t         shard_pins [$];
  logic [HASH_W-1:0]  running_hash;
  logic [SHARD_W-1:0] shard_modulus;
  logic [HASH_W-1:0]  mixed_hash;
  hash_result_t       want;
  shard_pin_t         pin;
  bit                 quiet_mode = 1'b0;
  int                 sink_hold = 0;
  int                 stalled_cycles = 0;
  int                 mismatches = 0;
  int                 bytes_seen = 0;
  int                 keys_seen = 0;
  int                 writes_seen = 0;
  int                 hashes_checked = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [HASH_W-1:0] fnv_fold(input logic [HASH_W-1:0] h,
                                                 input logic [KEY_W-1:0] b);
    return (h ^ {56'd0, b}) * FNV_MULT;
  endfunction

  function automatic logic [HASH_W-1:0] fmix_finish(input logic [HASH_W-1:0] h);
    logic [HASH_W-1:0] v;
    v = h ^ (h >> FMIX_SHR);
    v = v * FMIX_MULT_1;
    v = v ^ (v >> FMIX_SHR);
    v = v * FMIX_MULT_2;
    return v ^ (v >> FMIX_SHR);
  endfunction

  function automatic logic [SHARD_W-1:0] shard_of(input logic [HASH_W-1:0] h,
                                                  input logic [SHARD_W-1:0] m);
    if (m == '0) return '0;
    return SHARD_W'(h % {48'd0, m});
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_mode || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [KEY_W-1:0] random_key_byte();
    if ($urandom_range(0, 1) == 0) return KEY_W'($urandom_range(8'h2e, 8'h7a));
    return KEY_W'($urandom_range(0, 255));
  endfunction

  function automatic int random_key_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return 1;
    if (r < 85) return $urandom_range(2, 16);
    return $urandom_range(17, 48);
  endfunction

  function automatic logic [SHARD_W-1:0] phase_modulus(input int phase);
    case (phase)
      0: return 16'd1;
      1: return 16'd65535;
      2: return 16'd0;
      3: return 16'd7;
      4: return SHARDS_RESET;
      default: return SHARD_W'($urandom_range(1, 65535));
    endcase
  endfunction

  task automatic send_byte(input logic [KEY_W-1:0] b, input logic last);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      key_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    key_bus.valid     <= 1'b1;
    key_bus.key_byte  <= b;
    key_bus.last_byte <= last;
    @(posedge clk);
    while (!key_bus.ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    key_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending_hashes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // predict from what the block accepts
  always @(posedge clk) begin
    if (rst) begin
      running_hash  = OFFSET_BASIS;
      shard_modulus = SHARDS_RESET;
    end else begin
      if (psel && penable && pwrite && pready) begin
        writes_seen++;
        if (paddr == ADDR_SHARDS) shard_modulus = pwdata[SHARD_W-1:0];
      end
      if (key_bus.valid && key_bus.ready) begin
        bytes_seen++;
        running_hash = fnv_fold(running_hash, key_bus.key_byte);
        if (key_bus.last_byte) begin
          mixed_hash = fmix_finish(running_hash);
          pending_hashes.push_back('{mixed_hash, shard_of(mixed_hash, shard_modulus)});
          running_hash = OFFSET_BASIS;
          keys_seen++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && hash_bus.valid && hash_bus.ready) begin
      if (pending_hashes.size() == 0) begin
        $error("unexpected transaction: key_hash %h shard_number %0d",
               hash_bus.key_hash, hash_bus.shard_number);
        mismatches++;
      end else begin
        want = pending_hashes.pop_front();
        if (shard_pins.size() != 0) begin
          pin = shard_pins.pop_front();
          if (pin.pinned) want.shard_number = pin.shard;
        end
        if (hash_bus.key_hash !== want.key_hash) begin
          $error("key_hash: expected %h, actual %h", want.key_hash, hash_bus.key_hash);
          mismatches++;
        end
        if (hash_bus.shard_number !== want.shard_number) begin
          $error("shard_number: expected %0d, actual %0d",
                 want.shard_number, hash_bus.shard_number);
          mismatches++;
        end
        hashes_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (sink_hold != 0) begin
      hash_bus.ready <= 1'b0;
      sink_hold      <= sink_hold - 1;
    end else begin
      hash_bus.ready <= 1'b1;
      sink_hold      <= gap_len();
    end
  end

  initial begin
    while (stalled_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((key_bus.valid && key_bus.ready) || (hash_bus.valid && hash_bus.ready) ||
          (psel && penable && pwrite && pready))
        stalled_cycles = 0;
      else
        stalled_cycles++;
    end
    $error("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int phase_bytes;
    int key_len;
    rst               = 1'b1;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    key_bus.valid     = 1'b0;
    key_bus.key_byte  = '0;
    key_bus.last_byte = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      if (DIRECTED[i].kind == ROW_WRITE) begin
        wait_drained();
        write_reg(DIRECTED[i].addr, DIRECTED[i].value);
      end else begin
        send_byte(DIRECTED[i].value[KEY_W-1:0], DIRECTED[i].last);
        if (DIRECTED[i].last) shard_pins.push_back('{DIRECTED[i].pinned, DIRECTED[i].shard});
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      wait_drained();
      write_reg(ADDR_SHARDS, {16'($urandom), phase_modulus(phase)});
      quiet_mode  = (phase == 3 || phase == 6);
      phase_bytes = 0;
      while (phase_bytes < BYTES_PER_PHASE) begin
        key_len = random_key_len();
        for (int n = 1; n <= key_len; n++) send_byte(random_key_byte(), n == key_len);
        phase_bytes += key_len;
        if ($urandom_range(0, 39) == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_hashes.size() != 0) begin
      $error("%0d expected transactions never arrived", pending_hashes.size());
      mismatches++;
    end
    $display("Covered %0d key bytes in %0d keys across %0d register writes,",
             bytes_seen, keys_seen, writes_seen);
    $display("with shard counts 0, 1, 65535 and random; %0d hashes compared.", hashes_checked);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+src
src/fsh_pkg.sv
src/fsh_if.sv
src/fsh_mul64.sv
src/fsh_mod.sv
src/fnv1a_fmix_shard_hash.sv
tb/sv/tb.sv
